// ===== rtl/core/sgi_pkg.sv =====
package sgi_pkg;

   // default coordinate width (signed fixed point, all bits)
   localparam int COORD_BITS_DEF = 32;

   // width of the result coordinate ports
   localparam int PORT_BITS = 32;

endpackage

// ===== rtl/core/sgi_axis.sv =====
module sgi_axis #(
   parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [2*COORD_BITS+2:0]       n_mag,
   input  logic [COORD_BITS:0]           d_mag,
   input  logic [2*COORD_BITS+2:0]       den_mag,
   input  logic                          neg,
   input  logic signed [COORD_BITS-1:0]  start,
   output logic signed [COORD_BITS-1:0]  coord,
   output logic                          clip
);
   import sgi_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int DW  = C + 1;
   localparam int MW  = 2*DW + 1;
   localparam int NPW = MW + DW;
   localparam int LO  = MW / 2;
   localparam int HI  = MW - LO;
   localparam int SW  = C + 3;
   localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (C-1)) - 64'sd1);
   localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

   // partial products
   logic [LO+DW-1:0]       pl_ff;
   logic [HI+DW-1:0]       ph_ff;
   logic [MW-1:0]          da_ff, db_ff;
   logic                   na_ff, nb_ff;
   logic signed [C-1:0]    sa_ff, sb_ff;
   logic [NPW-1:0]         prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff   <= n_mag[LO-1:0] * d_mag;
         ph_ff   <= n_mag[MW-1:LO] * d_mag;
         da_ff   <= den_mag;
         na_ff   <= neg;
         sa_ff   <= start;
         prod_ff <= (NPW'(ph_ff) << LO) + NPW'(pl_ff);
         db_ff   <= da_ff;
         nb_ff   <= na_ff;
         sb_ff   <= sa_ff;
      end
   end

   // restoring divider, one quotient bit per stage
   logic [NPW-1:0]       rem_ff [0:C+1];
   logic [DW-1:0]        q_ff   [0:C+1];
   logic [MW-1:0]        den_ff [0:C+1];
   logic                 neg_ff [0:C+1];
   logic                 ovf_ff [0:C+1];
   logic signed [C-1:0]  st_ff  [0:C+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= prod_ff;
         q_ff[0]   <= '0;
         den_ff[0] <= db_ff;
         neg_ff[0] <= nb_ff;
         st_ff[0]  <= sb_ff;
         ovf_ff[0] <= prod_ff >= (NPW'(db_ff) << DW);
      end
   end

   for (genvar i = 0; i <= C; i++) begin : g_div
      localparam int K = C - i;
      logic [NPW-1:0] dsh;
      logic           ge;
      assign dsh = NPW'(den_ff[i]) << K;
      assign ge  = rem_ff[i] >= dsh;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= ge ? rem_ff[i] - dsh : rem_ff[i];
            q_ff[i+1]   <= q_ff[i] | (ge ? (DW'(1) << K) : '0);
            den_ff[i+1] <= den_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            st_ff[i+1]  <= st_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
         end
      end
   end

   logic signed [SW-1:0] qs, sum;
   assign qs  = signed'(SW'(q_ff[C+1]));
   assign sum = SW'(st_ff[C+1]) + (neg_ff[C+1] ? -qs : qs);

   always_ff @(posedge clock) begin
      if (en) begin
         if (ovf_ff[C+1]) begin
            coord <= neg_ff[C+1] ? C'(SMIN) : C'(SMAX);
            clip  <= 1'b1;
         end else if (sum > SMAX) begin
            coord <= C'(SMAX);
            clip  <= 1'b1;
         end else if (sum < SMIN) begin
            coord <= C'(SMIN);
            clip  <= 1'b1;
         end else begin
            coord <= C'(sum);
            clip  <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/core/segment_intersection_2d.sv =====
// channel | ports                      | direction
// req     | req_valid/req_stall, a_*, b_* | in: two segments, Q16.16
// rsp     | rsp_valid/rsp_stall, hit, parallel, cross_*, clipped | out: one item
//
// One item per cycle unless a stalled result holds the pipeline; the divider
// retires one quotient bit per stage (COORD_BITS + 1 stages per axis).
// Reset clears the valid bits only. A stalled result holds the whole pipeline
// and the input stalls in the same cycle; nothing is lost or repeated.
module segment_intersection_2d #(
   parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_a_start_x,
   input  logic [31:0] req_a_start_y,
   input  logic [31:0] req_a_end_x,
   input  logic [31:0] req_a_end_y,
   input  logic [31:0] req_b_start_x,
   input  logic [31:0] req_b_start_y,
   input  logic [31:0] req_b_end_x,
   input  logic [31:0] req_b_end_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic        rsp_parallel,
   output logic [31:0] rsp_cross_x,
   output logic [31:0] rsp_cross_y,
   output logic        rsp_clipped
);
   import sgi_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int DW = C + 1;
   localparam int PW = 2*DW;
   localparam int NW = PW + 1;
   localparam int L  = C + 5;

   logic en;

   function automatic logic signed [DW-1:0] ext(input logic [31:0] v);
      logic signed [C-1:0] t;
      t = signed'(v[C-1:0]);
      return DW'(t);
   endfunction

   // stage 1: differences
   logic                 v1_ff;
   logic signed [C-1:0]  ax1_ff, ay1_ff;
   logic signed [DW-1:0] dax1_ff, day1_ff, dbx1_ff, dby1_ff, vx1_ff, vy1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_valid;
      if (en) begin
         ax1_ff  <= signed'(req_a_start_x[C-1:0]);
         ay1_ff  <= signed'(req_a_start_y[C-1:0]);
         dax1_ff <= ext(req_a_end_x) - ext(req_a_start_x);
         day1_ff <= ext(req_a_end_y) - ext(req_a_start_y);
         dbx1_ff <= ext(req_b_end_x) - ext(req_b_start_x);
         dby1_ff <= ext(req_b_end_y) - ext(req_b_start_y);
         vx1_ff  <= ext(req_b_start_x) - ext(req_a_start_x);
         vy1_ff  <= ext(req_b_start_y) - ext(req_a_start_y);
      end
   end

   // stage 2: products
   logic                 v2_ff;
   logic signed [C-1:0]  ax2_ff, ay2_ff;
   logic signed [DW-1:0] dax2_ff, day2_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
      if (en) begin
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         dax2_ff <= dax1_ff;
         day2_ff <= day1_ff;
         p0_ff   <= PW'(dax1_ff) * PW'(dby1_ff);
         p1_ff   <= PW'(day1_ff) * PW'(dbx1_ff);
         p2_ff   <= PW'(dby1_ff) * PW'(vx1_ff);
         p3_ff   <= PW'(dbx1_ff) * PW'(vy1_ff);
         p4_ff   <= PW'(day1_ff) * PW'(vx1_ff);
         p5_ff   <= PW'(dax1_ff) * PW'(vy1_ff);
      end
   end

   // stage 3: denominator and numerators
   logic                 v3_ff;
   logic signed [C-1:0]  ax3_ff, ay3_ff;
   logic signed [DW-1:0] dax3_ff, day3_ff;
   logic signed [NW-1:0] den3_ff, nt3_ff, nu3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
      if (en) begin
         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
         dax3_ff <= dax2_ff;
         day3_ff <= day2_ff;
         den3_ff <= NW'(p0_ff) - NW'(p1_ff);
         nt3_ff  <= NW'(p2_ff) - NW'(p3_ff);
         nu3_ff  <= NW'(p4_ff) - NW'(p5_ff);
      end
   end

   // stage 4: magnitudes, signs and the hit test
   logic [NW-1:0] den_m, nt_m, nu_m;
   logic          in_t, in_u;
   assign den_m = den3_ff[NW-1] ? NW'(-den3_ff) : NW'(den3_ff);
   assign nt_m  = nt3_ff[NW-1]  ? NW'(-nt3_ff)  : NW'(nt3_ff);
   assign nu_m  = nu3_ff[NW-1]  ? NW'(-nu3_ff)  : NW'(nu3_ff);
   assign in_t  = (nt3_ff == '0) ||
                  ((nt3_ff[NW-1] == den3_ff[NW-1]) && (nt_m <= den_m));
   assign in_u  = (nu3_ff == '0) ||
                  ((nu3_ff[NW-1] == den3_ff[NW-1]) && (nu_m <= den_m));

   logic                v4_ff, hit4_ff, par4_ff, negx4_ff, negy4_ff;
   logic [NW-1:0]       den4_ff, nt4_ff;
   logic [DW-1:0]       dxm4_ff, dym4_ff;
   logic signed [C-1:0] ax4_ff, ay4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
      if (en) begin
         hit4_ff  <= in_t && in_u && (den3_ff != '0);
         par4_ff  <= den3_ff == '0;
         den4_ff  <= den_m;
         nt4_ff   <= nt_m;
         dxm4_ff  <= dax3_ff[DW-1] ? DW'(-dax3_ff) : DW'(dax3_ff);
         dym4_ff  <= day3_ff[DW-1] ? DW'(-day3_ff) : DW'(day3_ff);
         negx4_ff <= dax3_ff[DW-1] ^ nt3_ff[NW-1] ^ den3_ff[NW-1];
         negy4_ff <= day3_ff[DW-1] ^ nt3_ff[NW-1] ^ den3_ff[NW-1];
         ax4_ff   <= ax3_ff;
         ay4_ff   <= ay3_ff;
      end
   end

   // per-axis crossing point
   logic signed [C-1:0] cx, cy;
   logic                clx, cly;

   sgi_axis #(.COORD_BITS(C)) u_axis_x (
      .clock(clock), .en(en), .n_mag(nt4_ff), .d_mag(dxm4_ff), .den_mag(den4_ff),
      .neg(negx4_ff), .start(ax4_ff), .coord(cx), .clip(clx)
   );

   sgi_axis #(.COORD_BITS(C)) u_axis_y (
      .clock(clock), .en(en), .n_mag(nt4_ff), .d_mag(dym4_ff), .den_mag(den4_ff),
      .neg(negy4_ff), .start(ay4_ff), .coord(cy), .clip(cly)
   );

   // flags travel alongside the divider
   logic vl_ff [0:L-1];
   logic hl_ff [0:L-1];
   logic pl_ff [0:L-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < L; i++) vl_ff[i] <= 1'b0;
      end else if (en) begin
         vl_ff[0] <= v4_ff;
         for (int i = 1; i < L; i++) vl_ff[i] <= vl_ff[i-1];
      end
      if (en) begin
         hl_ff[0] <= hit4_ff;
         pl_ff[0] <= par4_ff;
         for (int i = 1; i < L; i++) begin
            hl_ff[i] <= hl_ff[i-1];
            pl_ff[i] <= pl_ff[i-1];
         end
      end
   end

   // hold everything while a result waits
   assign en        = !(vl_ff[L-1] && rsp_stall);
   assign req_stall = !en;

   assign rsp_valid    = vl_ff[L-1];
   assign rsp_hit      = hl_ff[L-1];
   assign rsp_parallel = pl_ff[L-1];
   assign rsp_cross_x  = pl_ff[L-1] ? '0 : PORT_BITS'(cx);
   assign rsp_cross_y  = pl_ff[L-1] ? '0 : PORT_BITS'(cy);
   assign rsp_clipped  = !pl_ff[L-1] && (clx || cly);

endmodule

// ===== sim/segment_intersection_2d_tb.sv =====
`timescale 1ns / 1ps

module segment_intersection_2d_tb;
   import sgi_pkg::*;

   typedef struct packed {
      logic [31:0] ax, ay, aex, aey, bx, by, bex, bey;
   } seg_pair_type;

   typedef struct packed {
      logic        hit;
      logic        parallel;
      logic [31:0] cx;
      logic [31:0] cy;
      logic        clipped;
   } crossing_type;

   class crossing_board;
      crossing_type pending[$];
      int        mismatches = 0;
      int        checked = 0;
      int        hits = 0;
      int        parallels = 0;
      int        clips = 0;

      function automatic logic [127:0] mag(logic signed [127:0] v);
         return (v < 0) ? -v : v;
      endfunction

      function automatic bit in_unit(logic signed [127:0] n, logic signed [127:0] den);
         if (n == 0) return 1;
         if ((n < 0) != (den < 0)) return 0;
         return mag(n) <= mag(den);
      endfunction

      function automatic logic [31:0] axis(logic signed [127:0] start,
            logic signed [127:0] d, logic signed [127:0] n,
            logic signed [127:0] den, inout bit clip);
         logic [127:0]        q;
         logic signed [127:0] sum;
         bit                  neg;
         neg = (d < 0) ^ (n < 0) ^ (den < 0);
         q = (mag(n) * mag(d)) / mag(den);
         if (q >= (128'd1 << 62)) begin
            clip = 1;
            return neg ? 32'h8000_0000 : 32'h7fff_ffff;
         end
         sum = neg ? start - $signed(q) : start + $signed(q);
         if (sum < -128'sd2147483648) begin
            clip = 1;
            return 32'h8000_0000;
         end
         if (sum > 128'sd2147483647) begin
            clip = 1;
            return 32'h7fff_ffff;
         end
         return sum[31:0];
      endfunction

      function automatic crossing_type predict(seg_pair_type p);
         logic signed [127:0] ax, ay, bx, by, dax, day, dbx, dby, vx, vy;
         logic signed [127:0] den, nt, nu, t;
         crossing_type        r;
         bit                  clip;
         ax = $signed(p.ax);
         ay = $signed(p.ay);
         bx = $signed(p.bx);
         by = $signed(p.by);
         t = $signed(p.aex); dax = t - ax;
         t = $signed(p.aey); day = t - ay;
         t = $signed(p.bex); dbx = t - bx;
         t = $signed(p.bey); dby = t - by;
         vx = bx - ax;
         vy = by - ay;
         den = dax * dby - day * dbx;
         r = '0;
         if (den == 0) begin
            r.parallel = 1;
            return r;
         end
         nt = dby * vx - dbx * vy;
         nu = day * vx - dax * vy;
         clip = 0;
         r.hit = in_unit(nt, den) && in_unit(nu, den);
         r.cx = axis(ax, dax, nt, den, clip);
         r.cy = axis(ay, day, nt, den, clip);
         r.clipped = clip;
         return r;
      endfunction

      function void note_pair(seg_pair_type p);
         pending.insert(pending.size(), predict(p));
      endfunction

      function void check_crossing(crossing_type got);
         crossing_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending.pop_front();
         checked++;
         hits += want.hit;
         parallels += want.parallel;
         clips += want.clipped;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: hit %b/%b par %b/%b x %h/%h y %h/%h clip %b/%b",
                  want.hit, got.hit, want.parallel, got.parallel, want.cx, got.cx,
                  want.cy, got.cy, want.clipped, got.clipped);
         end
      endfunction
   endclass

   localparam int N_RANDOM = 1200;
   localparam int CYCLE_LIMIT = 400000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_stall;
   logic         rsp_valid;
   logic         rsp_stall = 0;
   logic         rsp_hit, rsp_parallel, rsp_clipped;
   logic [31:0]  rsp_cross_x, rsp_cross_y;
   seg_pair_type cur = '0;

   crossing_board board = new();
   int          cycles = 0;
   int          sent = 0;

   segment_intersection_2d dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_start_x(cur.ax), .req_a_start_y(cur.ay),
      .req_a_end_x(cur.aex), .req_a_end_y(cur.aey),
      .req_b_start_x(cur.bx), .req_b_start_y(cur.by),
      .req_b_end_x(cur.bex), .req_b_end_y(cur.bey),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit), .rsp_parallel(rsp_parallel),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y),
      .rsp_clipped(rsp_clipped)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: alternate between free running, light and heavy stalling
   int stall_mode = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && !reset)
         board.check_crossing({rsp_hit, rsp_parallel, rsp_cross_x, rsp_cross_y,
                               rsp_clipped});
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(5, 80);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   function automatic logic [31:0] coord(int kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                        : 32'h8000_0000 + $urandom_range(0, 3);
         2: return 32'(int'($urandom_range(0, 2000)) - 1000) <<< 16;
         default: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
      endcase
   endfunction

   function automatic seg_pair_type random_pair();
      seg_pair_type p;
      int           kind, k;
      kind = $urandom_range(0, 9);
      k = (kind < 2) ? 0 : (kind < 3) ? 1 : (kind < 6) ? 2 : 3;
      p.ax = coord(k); p.ay = coord(k); p.aex = coord(k); p.aey = coord(k);
      p.bx = coord(k); p.by = coord(k); p.bex = coord(k); p.bey = coord(k);
      if (kind == 9) begin
         // make the second segment parallel to the first
         p.bex = p.bx + (p.aex - p.ax);
         p.bey = p.by + (p.aey - p.ay);
      end
      return p;
   endfunction

   function automatic seg_pair_type mk(int ax, int ay, int aex, int aey,
                                       int bx, int by, int bex, int bey);
      seg_pair_type p;
      p.ax = ax <<< 16; p.ay = ay <<< 16; p.aex = aex <<< 16; p.aey = aey <<< 16;
      p.bx = bx <<< 16; p.by = by <<< 16; p.bex = bex <<< 16; p.bey = bey <<< 16;
      return p;
   endfunction

   seg_pair_type directed[$];

   task automatic send_pair(seg_pair_type p);
      cur <= p;
      req_valid <= 1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      board.note_pair(p);
      sent++;
   endtask

   task automatic add_directed(seg_pair_type p);
      directed.insert(directed.size(), p);
   endtask

   initial begin
      int burst;
      add_directed('0);
      add_directed({8{32'h7fff_ffff}});
      add_directed({8{32'h8000_0000}});
      add_directed(mk(0, 0, 4, 4, 0, 4, 4, 0));
      add_directed(mk(0, 0, 4, 0, 4, -2, 4, 2));
      add_directed(mk(0, 0, 4, 0, 0, -2, 0, 2));
      add_directed(mk(0, 0, 4, 0, 5, -2, 5, 2));
      add_directed(mk(0, 0, 4, 0, 2, 1, 2, 3));
      add_directed(mk(0, 0, 4, 0, 1, 0, 6, 0));
      add_directed(mk(3, 3, 3, 3, 0, 0, 5, 5));
      add_directed(mk(0, 0, 1, 1, 1, 1, 2, 2));
      add_directed({32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000});
      add_directed({32'h0, 32'h0, 32'h1, 32'h0,
                    32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff});
      add_directed({32'h0, 32'h0, 32'h1, 32'h1,
                    32'h7fff_0000, 32'h0, 32'h7fff_0000, 32'h1});
      add_directed({32'h8000_0000, 32'h0, 32'h8000_0001, 32'h1,
                    32'h0, 32'h0, 32'h0, 32'h1});
      add_directed({32'hffff_ffff, 32'h1, 32'h1, 32'hffff_ffff,
                    32'hffff_ffff, 32'hffff_ffff, 32'h1, 32'h1});
      repeat (6) @(posedge clock);
      reset <= 0;
      foreach (directed[i]) send_pair(directed[i]);
      while (sent < directed.size() + N_RANDOM) begin
         burst = $urandom_range(1, 40);
         repeat (burst) send_pair(random_pair());
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("%0d segment pairs checked: %0d hits, %0d parallel, %0d saturated",
               board.checked, board.hits, board.parallels, board.clips);
      $display("mismatches counted: %0d", board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sgi_pkg.sv
rtl/core/sgi_axis.sv
rtl/core/segment_intersection_2d.sv
sim/segment_intersection_2d_tb.sv
